>>> rtl/vn_pkg.sv
// ============================================================================
// vn_pkg
// Shared defaults for the 3-component vector normalizer.
// ============================================================================
`default_nettype none

package vn_pkg;

  // Default width of one input component (signed, Q8.8 at 16 bits).
  localparam int COMPONENT_WIDTH_DEF = 16;

  // Default number of fraction bits in each normalized output component.
  localparam int OUT_FRAC_BITS_DEF = 14;

endpackage

`default_nettype wire

>>> rtl/vn_if.sv
// ============================================================================
// vn_in_if / vn_out_if
// Valid/ready channels for the vector normalizer input and result streams.
// ============================================================================
`default_nettype none

interface vn_in_if import vn_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] in_x;
  logic signed [COMPONENT_WIDTH-1:0] in_y;
  logic signed [COMPONENT_WIDTH-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vn_out_if import vn_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic signed [OUT_FRAC_BITS+1:0] out_x;
  logic signed [OUT_FRAC_BITS+1:0] out_y;
  logic signed [OUT_FRAC_BITS+1:0] out_z;
  logic                            zero_length;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output zero_length, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input zero_length, output ready);
endinterface

`default_nettype wire

>>> rtl/vector3_normalize_top.sv
// ============================================================================
// vector3_normalize_top
// Fully pipelined 3D vector normalizer: signed fixed-point in, unit vector out.
// ============================================================================
// Pipeline: stages A, B and C, the division stages, the square-root stages
//   and the output register, in that order, between input and result.
// Throughput: one transaction per cycle; every stage is a register slice fed
//   by one negation, one multiplier, one three-input add or one
//   compare-and-subtract. A result held by the sink stalls the whole pipeline.
// Reset: synchronous active-low rst_n clears all stage valid bits; data
//   registers are not reset.
// ============================================================================
`default_nettype none

module vector3_normalize_top import vn_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vn_in_if.sink     in_ch,
  vn_out_if.source  out_ch
);

  // Derived widths.
  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = OUT_FRAC_BITS;
  localparam int SW  = 2 * W;        // one square, and the sum of three squares
  localparam int RMW = SW + 1;       // division remainder after doubling
  localparam int QW  = 2 * F + 1;    // scaled ratio c*c*2^(2F)/S, integer bit included
  localparam int EW  = 2 * F + 3;    // square-root residue and trial value
  localparam int RTW = F + 1;        // root magnitude, up to 2^F
  localparam int OW  = F + 2;        // signed output component

  // The whole pipeline moves together. It advances whenever the result
  // register is empty or its transaction is being taken downstream in the
  // same cycle. While a finished result waits for the sink, every stage
  // holds and the input is not ready, even if there are bubbles behind it.
  logic adv;
  logic out_v_r;
  assign adv         = ~out_v_r | out_ch.ready;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // Stage A: absolute values and signs of the three components.
  // --------------------------------------------------------------------------
  logic signed [W-1:0] in_c [3];
  assign in_c[0] = in_ch.in_x;
  assign in_c[1] = in_ch.in_y;
  assign in_c[2] = in_ch.in_z;

  logic         a_v_r;
  logic [W-1:0] a_mag_r [3];
  logic [2:0]   a_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a_mag_r[k] <= in_c[k][W-1] ? W'(-in_c[k]) : W'(in_c[k]);
        a_neg_r[k] <= in_c[k][W-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: one multiplier per component forms the squares. An all-zero
  // vector is flagged here; it still passes the divider and comes out as zeros.
  // --------------------------------------------------------------------------
  logic          b_v_r;
  logic [SW-1:0] b_sq_r [3];
  logic [2:0]    b_neg_r;
  logic          b_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b_sq_r[k] <= SW'(a_mag_r[k]) * SW'(a_mag_r[k]);
      end
      b_neg_r  <= a_neg_r;
      b_zero_r <= (a_mag_r[0] == '0) && (a_mag_r[1] == '0) && (a_mag_r[2] == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sum of squares. Three squares of magnitudes up to 2^(W-1) stay below
  // 2^(2W), so the sum fits the square width.
  // --------------------------------------------------------------------------
  logic          c_v_r;
  logic [SW-1:0] c_sq_r [3];
  logic [SW-1:0] c_sum_r;
  logic [2:0]    c_neg_r;
  logic          c_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sq_r   <= b_sq_r;
      c_sum_r  <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_neg_r  <= b_neg_r;
      c_zero_r <= b_zero_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: restoring long division, one quotient bit per stage, computing
  // R = floor(c*c * 2^(2F) / S) for each component in parallel lanes. Since
  // c*c never exceeds S, the first stage yields the single integer bit and
  // the remaining 2F stages yield the fraction bits.
  // Signals named dvi_* are the inputs of division stage j.
  // --------------------------------------------------------------------------
  logic           dvi_v    [QW];
  logic [RMW-1:0] dvi_rem  [QW][3];
  logic [QW-1:0]  dvi_q    [QW][3];
  logic [SW-1:0]  dvi_den  [QW];
  logic [2:0]     dvi_neg  [QW];
  logic           dvi_zero [QW];

  logic           dv_v_r    [QW];
  logic [RMW-1:0] dv_rem_r  [QW][3];
  logic [QW-1:0]  dv_q_r    [QW][3];
  logic [SW-1:0]  dv_den_r  [QW];
  logic [2:0]     dv_neg_r  [QW];
  logic           dv_zero_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    if (j == 0) begin : g_first
      assign dvi_v[j]    = c_v_r;
      assign dvi_den[j]  = c_sum_r;
      assign dvi_neg[j]  = c_neg_r;
      assign dvi_zero[j] = c_zero_r;
      for (genvar k = 0; k < 3; k++) begin : g_lane_in
        assign dvi_rem[j][k] = RMW'(c_sq_r[k]);
        assign dvi_q[j][k]   = '0;
      end
    end else begin : g_next
      assign dvi_v[j]    = dv_v_r[j-1];
      assign dvi_den[j]  = dv_den_r[j-1];
      assign dvi_neg[j]  = dv_neg_r[j-1];
      assign dvi_zero[j] = dv_zero_r[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane_in
        assign dvi_rem[j][k] = dv_rem_r[j-1][k];
        assign dvi_q[j][k]   = dv_q_r[j-1][k];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [RMW-1:0] trial;
      logic           take;
      logic [RMW-1:0] rem_nxt;
      logic [QW-1:0]  q_nxt;

      always_comb begin
        trial   = (j == 0) ? dvi_rem[j][k] : {dvi_rem[j][k][RMW-2:0], 1'b0};
        take    = trial >= RMW'(dvi_den[j]);
        rem_nxt = take ? (trial - RMW'(dvi_den[j])) : trial;
        q_nxt   = {dvi_q[j][k][QW-2:0], take};
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[j][k] <= rem_nxt;
          dv_q_r[j][k]   <= q_nxt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j] <= dvi_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den_r[j]  <= dvi_den[j];
        dv_neg_r[j]  <= dvi_neg[j];
        dv_zero_r[j] <= dvi_zero[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root: digit-by-digit integer root of R, one root bit per stage
  // from bit F down to bit 0. The residue e holds R minus the square of the
  // partial root; bit i is set when e >= root*2^(i+1) + 2^(2i).
  // floor(sqrt(R)) equals the truncated magnitude |c|*2^F/sqrt(S).
  // --------------------------------------------------------------------------
  logic           sqi_v    [RTW];
  logic [EW-1:0]  sqi_e    [RTW][3];
  logic [RTW-1:0] sqi_root [RTW][3];
  logic [2:0]     sqi_neg  [RTW];
  logic           sqi_zero [RTW];

  logic           sq_v_r    [RTW];
  logic [EW-1:0]  sq_e_r    [RTW][3];
  logic [RTW-1:0] sq_root_r [RTW][3];
  logic [2:0]     sq_neg_r  [RTW];
  logic           sq_zero_r [RTW];

  for (genvar s = 0; s < RTW; s++) begin : g_sqrt
    localparam int BIT = F - s;

    if (s == 0) begin : g_first
      assign sqi_v[s]    = dv_v_r[QW-1];
      assign sqi_neg[s]  = dv_neg_r[QW-1];
      assign sqi_zero[s] = dv_zero_r[QW-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane_in
        assign sqi_e[s][k]    = EW'(dv_q_r[QW-1][k]);
        assign sqi_root[s][k] = '0;
      end
    end else begin : g_next
      assign sqi_v[s]    = sq_v_r[s-1];
      assign sqi_neg[s]  = sq_neg_r[s-1];
      assign sqi_zero[s] = sq_zero_r[s-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane_in
        assign sqi_e[s][k]    = sq_e_r[s-1][k];
        assign sqi_root[s][k] = sq_root_r[s-1][k];
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [EW-1:0]  trial;
      logic           take;
      logic [EW-1:0]  e_nxt;
      logic [RTW-1:0] root_nxt;

      always_comb begin
        trial    = (EW'(sqi_root[s][k]) << (BIT + 1)) + (EW'(1) << (2 * BIT));
        take     = sqi_e[s][k] >= trial;
        e_nxt    = take ? (sqi_e[s][k] - trial) : sqi_e[s][k];
        root_nxt = take ? (sqi_root[s][k] | (RTW'(1) << BIT)) : sqi_root[s][k];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          sq_e_r[s][k]    <= e_nxt;
          sq_root_r[s][k] <= root_nxt;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s] <= 1'b0;
      end else if (adv) begin
        sq_v_r[s] <= sqi_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_neg_r[s]  <= sqi_neg[s];
        sq_zero_r[s] <= sqi_zero[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: restore the signs, force zeros for a zero-length vector.
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] out_c_r [3];
  logic                 out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= sq_v_r[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (sq_zero_r[RTW-1]) begin
          out_c_r[k] <= '0;
        end else if (sq_neg_r[RTW-1][k]) begin
          out_c_r[k] <= OW'(0) - OW'(sq_root_r[RTW-1][k]);
        end else begin
          out_c_r[k] <= OW'(sq_root_r[RTW-1][k]);
        end
      end
      out_zero_r <= sq_zero_r[RTW-1];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_x       = out_c_r[0];
  assign out_ch.out_y       = out_c_r[1];
  assign out_ch.out_z       = out_c_r[2];
  assign out_ch.zero_length = out_zero_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A zero-length vector must come out as all zeros.
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_zero_r) |-> (out_c_r[0] == '0 && out_c_r[1] == '0 && out_c_r[2] == '0))
    else $error("zero-length result carries nonzero components");

  // The normalized x component never exceeds unit magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_c_r[0]) <= $signed(OW'(1) << F) &&
                 $signed(out_c_r[0]) >= -$signed(OW'(1) << F)))
    else $error("normalized x component out of unit range");

  // A stalled pipeline holds its result register and the stage feeding it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (out_v_r && $stable(out_c_r[1]) && $stable(sq_v_r[RTW-1])))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

>>> tb/tb_vector3_normalize_top.sv
// ============================================================================
// Vector normalizer testbench
// Drives 3-component Q8.8 vectors through valid/ready channels, computes the
// exact truncated Q1.14 unit vector for each one, and compares every result
// transaction in order, under random idling and one long output stall.
// ============================================================================
`timescale 1ns / 1ps

module tb_vector3_normalize_top import vn_pkg::*; ();

  localparam int CW = COMPONENT_WIDTH_DEF;
  localparam int FB = OUT_FRAC_BITS_DEF;
  localparam int OW = FB + 2;
  localparam int N_RANDOM = 1250;
  localparam int N_DIRECTED = 20;
  localparam int MAX_ERR_PRINT = 10;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
    logic                 zero_length;
  } unit_vec_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   known;   // expected result typed in below
    unit_vec_t            res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vn_in_if  #(.COMPONENT_WIDTH(CW)) in_ch ();
  vn_out_if #(.OUT_FRAC_BITS(FB))   out_ch ();

  vector3_normalize_top #(.COMPONENT_WIDTH(CW), .OUT_FRAC_BITS(FB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  unit_vec_t expected_units[$];
  int        n_mismatch = 0;
  int        n_results = 0;
  int        n_zero_seen = 0;
  bit        input_done = 1'b0;

  // Integer square root of a 64-bit value, bit by bit.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One component: floor(|c| * 2^FB / sqrt(S)) as floor(sqrt(floor(c^2 2^2FB / S))).
  // c^2 < 2^31 and the shift is 28 bits, so 128-bit math holds it exactly.
  function automatic logic signed [OW-1:0] unit_component(longint signed c,
                                                          longint unsigned sum_sq);
    logic [127:0]    num;
    longint unsigned mag;
    longint unsigned q;
    mag = (c < 0) ? -c : c;
    num = (128'(mag * mag) << (2 * FB)) / 128'(sum_sq);
    q = root_floor(num[63:0]);
    return (c < 0) ? OW'(-q) : OW'(q);
  endfunction

  function automatic unit_vec_t normalize_vec(logic signed [CW-1:0] x,
                                              logic signed [CW-1:0] y,
                                              logic signed [CW-1:0] z);
    unit_vec_t       u;
    longint signed   cx, cy, cz;
    longint unsigned sum_sq;
    cx = x;
    cy = y;
    cz = z;
    sum_sq = cx * cx + cy * cy + cz * cz;
    if (sum_sq == 0) begin
      u = '{x: '0, y: '0, z: '0, zero_length: 1'b1};
    end else begin
      u.x = unit_component(cx, sum_sq);
      u.y = unit_component(cy, sum_sq);
      u.z = unit_component(cz, sum_sq);
      u.zero_length = 1'b0;
    end
    return u;
  endfunction

  localparam logic signed [OW-1:0] ONE = OW'(1 << FB);
  localparam logic signed [OW-1:0] MONE = -ONE;

  // Directed rows: zero vector, single axes at the extremes, mixed extremes.
  vec_row_t directed_rows[N_DIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1, '{'0, '0, '0, 1'b1}},
    '{16'sd1,      16'sd0,      16'sd0,      1, '{ONE, '0, '0, 1'b0}},
    '{16'sd0,      -16'sd1,     16'sd0,      1, '{'0, MONE, '0, 1'b0}},
    '{16'sd0,      16'sd0,      16'sd32767,  1, '{'0, '0, ONE, 1'b0}},
    '{-16'sd32768, 16'sd0,      16'sd0,      1, '{MONE, '0, '0, 1'b0}},
    '{16'sd0,      -16'sd32768, 16'sd0,      1, '{'0, MONE, '0, 1'b0}},
    '{16'sd0,      16'sd0,      -16'sd32768, 1, '{'0, '0, MONE, 1'b0}},
    '{16'sd256,    16'sd0,      16'sd0,      1, '{ONE, '0, '0, 1'b0}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 0, '0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  0, '0},
    '{16'sd32767,  -16'sd32768, 16'sd1,      0, '0},
    '{16'sd1,      16'sd1,      16'sd1,      0, '0},
    '{-16'sd1,     16'sd1,      -16'sd1,     0, '0},
    '{16'sd3,      16'sd4,      16'sd0,      0, '0},
    '{16'sd0,      -16'sd3,     16'sd4,      0, '0},
    '{16'sd1,      16'sd32767,  16'sd0,      0, '0},
    '{16'sd1,      16'sd1,      -16'sd32768, 0, '0},
    '{16'sh5555,   16'shAAAA,   16'sh0F0F,   0, '0},
    '{16'shAAAA,   16'sh5555,   16'shF0F0,   0, '0},
    '{16'sd0,      16'sd0,      16'sd0,      1, '{'0, '0, '0, 1'b1}}
  };

  // Hands one vector to the block at the falling edge and waits for acceptance.
  // Valid stays high into the next transaction when no idle cycles are drawn.
  task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z, unit_vec_t res);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= x;
    in_ch.in_y  <= y;
    in_ch.in_z  <= z;
    expected_units.push_back(res);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random component: mostly full range, sometimes small or at an extreme.
  function automatic logic signed [CW-1:0] rand_component();
    case ($urandom_range(0, 5))
      0:       return CW'($urandom_range(0, 7)) - CW'(3);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2:       return 16'sd0;
      default: return CW'($urandom);
    endcase
  endfunction

  // Stimulus: reset, directed table, then random vectors.
  initial begin
    logic signed [CW-1:0] rx, ry, rz;
    in_ch.valid = 1'b0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].known ? directed_rows[i].res
                  : normalize_vec(directed_rows[i].x, directed_rows[i].y,
                                  directed_rows[i].z));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      rx = rand_component();
      ry = rand_component();
      rz = rand_component();
      send_vector(rx, ry, rz, normalize_vec(rx, ry, rz));
    end
    in_ch.valid <= 1'b0;
    input_done = 1'b1;
  end

  // Receiver: random stalls at first, then one long hold-off that fills the
  // pipeline, then random idling for the rest of the run.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    repeat (300) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
      @(negedge clk);
    end
    out_ch.ready <= 1'b0;
    repeat (200) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 3);
      // About one stretch in four, drawn at random, runs with ready held high.
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    unit_vec_t want;
    unit_vec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.zero_length};
      n_results++;
      if (got.zero_length) n_zero_seen++;
      if (expected_units.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_ERR_PRINT)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d zl=%0b",
                   got.x, got.y, got.z, got.zero_length);
      end else begin
        want = expected_units.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_ERR_PRINT)
            $display("ERROR: result %0d expected (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                     n_results, want.x, want.y, want.z, want.zero_length,
                     got.x, got.y, got.z, got.zero_length);
        end
      end
    end
  end

  // End of run: drain, then allow the pipeline latency for stray results.
  initial begin
    wait (input_done);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (3 * FB + 20) @(posedge clk);
    $display("Checked %0d normalized vectors (%0d zero-length) with random idling",
             n_results, n_zero_seen);
    if (n_mismatch == 0 && expected_units.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #400000;
    $display("Timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
